@@ rtl/core/wtrs_pkg.sv @@
// Shared types, constants and helpers of the weighted table route selector.
package wtrs_pkg;

  localparam int unsigned NumVnets = 4;
  localparam int unsigned NumLinks = 16;
  localparam int unsigned DestBits = 64;

  localparam int unsigned VnetW   = $clog2(NumVnets);
  localparam int unsigned LinkW   = $clog2(NumLinks);
  localparam int unsigned CntW    = $clog2(NumLinks + 1);
  localparam int unsigned WeightW = 16;
  localparam int unsigned BestW   = WeightW + 1;
  localparam int unsigned PortW   = 4;
  localparam int unsigned IdW     = 8;
  localparam int unsigned DivW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  localparam logic [BestW-1:0] BestInit = {1'b1, {WeightW{1'b0}}};
  localparam logic [15:0]      LfsrSeed = 16'hACE1;

  localparam logic [1:0] KindMask   = 2'd0;
  localparam logic [1:0] KindWeight = 2'd1;
  localparam logic [1:0] KindRoute  = 2'd2;
  localparam logic [1:0] KindSpare  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgRoutingMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMeshCols    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRouterId    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOrdered     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPortEast    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPortWest    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPortNorth   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgPortSouth   = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  vnet;
    logic [3:0]  link;
    logic [63:0] dest_mask;
    logic [15:0] weight;
    logic [7:0]  dst_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_port;
    logic       no_route;
  } out_item_t;

  typedef struct packed {
    logic                mask_we;
    logic                weight_we;
    logic [VnetW-1:0]    vnet;
    logic [LinkW-1:0]    link;
    logic [DestBits-1:0] mask;
    logic [WeightW-1:0]  weight;
  } cell_wr_t;

  typedef struct packed {
    logic [VnetW-1:0]    vnet;
    logic [DestBits-1:0] want;
  } cell_req_t;

  typedef struct packed {
    logic [BestW-1:0] best;
    logic [CntW-1:0]  cnt;
  } scan_tok_t;

  typedef struct packed {
    logic [CntW-1:0]  seen;
    logic             found;
    logic [LinkW-1:0] port;
  } sel_tok_t;

  function automatic logic [15:0] lfsr_advance(input logic [15:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[15:1]};
  endfunction

endpackage

@@ rtl/core/wtrs_cell.sv @@
// One link cell: holds the link's masks, weight and valid bit, and passes scan and selection tokens on.
module wtrs_cell #(
  parameter int unsigned LinkIdx = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wtrs_pkg::cell_wr_t                 wr_i,
  input  wtrs_pkg::cell_req_t                req_i,
  input  logic [wtrs_pkg::BestW-1:0]         ref_best_i,
  input  logic [wtrs_pkg::CntW-1:0]          pick_i,
  input  wtrs_pkg::scan_tok_t                scan_i,
  output wtrs_pkg::scan_tok_t                scan_o,
  input  wtrs_pkg::sel_tok_t                 sel_i,
  output wtrs_pkg::sel_tok_t                 sel_o
);

  localparam logic [wtrs_pkg::LinkW-1:0] Idx = LinkIdx[wtrs_pkg::LinkW-1:0];

  logic [wtrs_pkg::DestBits-1:0] mask_q [wtrs_pkg::NumVnets];
  logic [wtrs_pkg::WeightW-1:0]  weight_q;
  logic                          valid_q;
  logic                          match;
  logic [wtrs_pkg::BestW-1:0]    wext;
  wtrs_pkg::scan_tok_t           scan_d, scan_q;
  wtrs_pkg::sel_tok_t            sel_d, sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.mask_we && wr_i.link == Idx) begin
      mask_q[wr_i.vnet] <= wr_i.mask;
    end
    if (wr_i.weight_we && wr_i.link == Idx) begin
      weight_q <= wr_i.weight;
    end
    scan_q <= scan_d;
    sel_q  <= sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.weight_we && wr_i.link == Idx) begin
      valid_q <= 1'b1;
    end
  end

  assign match = valid_q && (|(mask_q[req_i.vnet] & req_i.want));
  assign wext  = {1'b0, weight_q};

  always_comb begin
    scan_d = scan_i;
    if (match && wext < scan_i.best) begin
      scan_d.best = wext;
      scan_d.cnt  = {{(wtrs_pkg::CntW-1){1'b0}}, 1'b1};
    end else if (match && wext == scan_i.best) begin
      scan_d.cnt = scan_i.cnt + 1'b1;
    end
  end

  always_comb begin
    sel_d = sel_i;
    if (match && wext == ref_best_i && !sel_i.found) begin
      if (sel_i.seen == pick_i) begin
        sel_d.found = 1'b1;
        sel_d.port  = Idx;
      end else begin
        sel_d.seen = sel_i.seen + 1'b1;
      end
    end
  end

  assign scan_o = scan_q;
  assign sel_o  = sel_q;

endmodule

@@ rtl/core/wtrs_divu.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module wtrs_divu #(
  parameter int unsigned Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] quo_q, rem_q, div_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic [Width:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[Width-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q && cnt_q != '0) begin
      quo_q <= {quo_q[Width-2:0], fits};
      if (fits) begin
        rem_q <= Width'(trial - {1'b0, div_q});
      end else begin
        rem_q <= trial[Width-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntW'(Width);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign busy_o = run_q;
  assign done_o = run_q && cnt_q == '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/weighted_table_route_select.sv @@
// Top level of the weighted table route selector: control, link cell chain and divider.
//
// Items arrive on in_valid_i/in_ready_o as wtrs_pkg::in_item_t. Mask and weight
// writes are stored in the accepting cycle and give no result. A route request
// gives one out_item_t on out_valid_o/out_ready_o. Registers are written over
// cfg_valid_i/cfg_ready_o (always ready) by index; the user must write them only
// while the block is idle, which the block itself does not enforce. One request
// is handled at a time; in_ready_o is high whenever no request is in flight,
// also while a finished result waits in the output register. Table lookup: a
// weight scan down the cell chain, a division for an unordered pick, a
// selection pass down the chain, then a load of the output register; when no
// link matches, the no-route result goes straight to the output register. XY
// routing: two divisions by the column count (router id, then destination),
// then the output register is loaded.
// Reset clears the link valid bits, loads the LFSR seed and the register reset
// values; masks and weights are undefined until written.
// When the receiver stalls, the result holds and the next finished request waits
// for the output register to empty.
module weighted_table_route_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  wtrs_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output wtrs_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wtrs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wtrs_pkg::CfgW-1:0]            cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_MOD  = 7'b0000100,
    S_SEL  = 7'b0001000,
    S_DIVA = 7'b0010000,
    S_DIVB = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  localparam int unsigned N = wtrs_pkg::NumLinks;

  state_e st_q, st_d;

  logic       mode_q;
  logic [7:0] cols_q, id_q;
  logic [3:0] ordered_q, east_q, west_q, north_q, south_q;
  logic [15:0] lfsr_q;

  wtrs_pkg::cell_req_t              req_q;
  logic [7:0]                       dest_q;
  logic [wtrs_pkg::CntW-1:0]        cnt_q, count_q, pick_q;
  logic [wtrs_pkg::BestW-1:0]       best_q;
  logic [7:0]                       mx_q, my_q;
  wtrs_pkg::out_item_t              res_q, out_q;
  logic                             out_valid_q;

  logic in_acc, route_acc, xy_acc;
  logic [7:0] cols;
  wtrs_pkg::cell_wr_t wr;
  wtrs_pkg::scan_tok_t scan_tok [N+1];
  wtrs_pkg::sel_tok_t  sel_tok  [N+1];

  logic                          div_start, div_busy, div_done;
  logic [wtrs_pkg::DivW-1:0]     div_a, div_b, div_quo, div_rem;
  logic [15:0]                   lfsr_adv;
  logic                          unordered;
  logic [7:0]                    dx, dy;
  logic [3:0]                    xy_port;

  assign in_ready_o  = (st_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign route_acc   = in_acc && in_item_i.kind == wtrs_pkg::KindRoute;
  assign xy_acc      = route_acc && mode_q && in_item_i.dst_id != id_q;
  assign cols        = (cols_q == '0) ? 8'd1 : cols_q;
  assign cfg_ready_o = 1'b1;
  assign lfsr_adv    = wtrs_pkg::lfsr_advance(lfsr_q);
  assign unordered   = !ordered_q[req_q.vnet];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      cols_q    <= 8'd4;
      id_q      <= 8'd0;
      ordered_q <= 4'd0;
      east_q    <= 4'd0;
      west_q    <= 4'd1;
      north_q   <= 4'd2;
      south_q   <= 4'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wtrs_pkg::CfgRoutingMode: mode_q    <= cfg_data_i[0];
        wtrs_pkg::CfgMeshCols:    cols_q    <= cfg_data_i;
        wtrs_pkg::CfgRouterId:    id_q      <= cfg_data_i;
        wtrs_pkg::CfgOrdered:     ordered_q <= cfg_data_i[3:0];
        wtrs_pkg::CfgPortEast:    east_q    <= cfg_data_i[3:0];
        wtrs_pkg::CfgPortWest:    west_q    <= cfg_data_i[3:0];
        wtrs_pkg::CfgPortNorth:   north_q   <= cfg_data_i[3:0];
        wtrs_pkg::CfgPortSouth:   south_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wr.mask_we   = in_acc && in_item_i.kind == wtrs_pkg::KindMask;
    wr.weight_we = in_acc && in_item_i.kind == wtrs_pkg::KindWeight;
    wr.vnet      = in_item_i.vnet;
    wr.link      = in_item_i.link;
    wr.mask      = in_item_i.dest_mask[wtrs_pkg::DestBits-1:0];
    wr.weight    = in_item_i.weight;
  end

  assign scan_tok[0] = '{best: wtrs_pkg::BestInit, cnt: '0};
  assign sel_tok[0]  = '{seen: '0, found: 1'b0, port: '0};

  for (genvar k = 0; k < N; k++) begin : g_cell
    wtrs_cell #(.LinkIdx(k)) u_cell (
      .clk_i,
      .rst_ni,
      .wr_i       (wr),
      .req_i      (req_q),
      .ref_best_i (best_q),
      .pick_i     (pick_q),
      .scan_i     (scan_tok[k]),
      .scan_o     (scan_tok[k+1]),
      .sel_i      (sel_tok[k]),
      .sel_o      (sel_tok[k+1])
    );
  end

  wtrs_divu #(.Width(wtrs_pkg::DivW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  logic scan_end;
  assign scan_end = (st_q == S_SCAN) && cnt_q == wtrs_pkg::CntW'(N);

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    if (xy_acc) begin
      div_start = 1'b1;
      div_a     = {8'd0, id_q};
      div_b     = {8'd0, cols};
    end else if (st_q == S_DIVA && div_done) begin
      div_start = 1'b1;
      div_a     = {8'd0, dest_q};
      div_b     = {8'd0, cols};
    end else if (scan_end && scan_tok[N].cnt != '0 && unordered) begin
      div_start = 1'b1;
      div_a     = lfsr_adv;
      div_b     = {{(wtrs_pkg::DivW-wtrs_pkg::CntW){1'b0}}, scan_tok[N].cnt};
    end
  end

  assign dx = div_rem[7:0];
  assign dy = div_quo[7:0];
  always_comb begin
    if (dx != mx_q) begin
      xy_port = (dx > mx_q) ? east_q : west_q;
    end else begin
      xy_port = (dy >= my_q) ? north_q : south_q;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (xy_acc) begin
          st_d = S_DIVA;
        end else if (route_acc) begin
          st_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          if (scan_tok[N].cnt == '0) begin
            st_d = S_DONE;
          end else if (unordered) begin
            st_d = S_MOD;
          end else begin
            st_d = S_SEL;
          end
        end
      end
      S_MOD:  if (div_done) st_d = S_SEL;
      S_SEL:  if (cnt_q == wtrs_pkg::CntW'(N)) st_d = S_DONE;
      S_DIVA: if (div_done) st_d = S_DIVB;
      S_DIVB: if (div_done) st_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      lfsr_q      <= wtrs_pkg::LfsrSeed;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_d != st_q) begin
        cnt_q <= '0;
      end else if (st_q == S_SCAN || st_q == S_SEL) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (scan_end && scan_tok[N].cnt != '0 && unordered) begin
        lfsr_q <= lfsr_adv;
      end
      if (st_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (route_acc) begin
      req_q.vnet <= in_item_i.vnet;
      req_q.want <= in_item_i.dest_mask[wtrs_pkg::DestBits-1:0];
      dest_q     <= in_item_i.dst_id;
    end
    if (scan_end) begin
      best_q  <= scan_tok[N].best;
      count_q <= scan_tok[N].cnt;
      pick_q  <= '0;
      if (scan_tok[N].cnt == '0) begin
        res_q <= '{out_port: 4'd0, no_route: 1'b1};
      end
    end
    if (st_q == S_MOD && div_done) begin
      pick_q <= div_rem[wtrs_pkg::CntW-1:0];
    end
    if (st_q == S_SEL && cnt_q == wtrs_pkg::CntW'(N)) begin
      res_q <= '{out_port: 4'(sel_tok[N].port), no_route: 1'b0};
    end
    if (st_q == S_DIVA && div_done) begin
      mx_q <= div_rem[7:0];
      my_q <= div_quo[7:0];
    end
    if (st_q == S_DIVB && div_done) begin
      res_q <= '{out_port: xy_port, no_route: 1'b0};
    end
    if (st_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!div_busy || div_done)) else $error("divider restarted while busy");
  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SEL) |-> (pick_q < count_q)) else $error("pick beyond candidate count");
  a_sel_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SEL && cnt_q == wtrs_pkg::CntW'(N)) |-> sel_tok[N].found)
    else $error("selection pass found no candidate");
`endif

endmodule

@@ bench/tb_weighted_table_route_select.sv @@
// Self-checking bench for the weighted table route selector: driver, monitor and predictor.
module tb_weighted_table_route_select;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  wtrs_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wtrs_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [wtrs_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [wtrs_pkg::CfgW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  weighted_table_route_select dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Model copy of registers and tables.
  logic        mdl_mode = 1'b0;
  logic [7:0]  mdl_cols = 8'd4;
  logic [7:0]  mdl_id = 8'd0;
  logic [3:0]  mdl_ordered = 4'd0;
  logic [3:0]  mdl_east = 4'd0, mdl_west = 4'd1, mdl_north = 4'd2, mdl_south = 4'd3;
  logic [63:0] mdl_masks [wtrs_pkg::NumVnets][wtrs_pkg::NumLinks];
  logic [15:0] mdl_weights [wtrs_pkg::NumLinks];
  logic [15:0] mdl_valid = '0;
  logic [15:0] mdl_lfsr = wtrs_pkg::LfsrSeed;

  wtrs_pkg::in_item_t  item_q [$];
  wtrs_pkg::out_item_t route_q [$];

  bit          in_taken = 1'b0;
  bit          idle_ok = 1'b1;
  int          in_gap = 0, out_gap = 0;
  int          cfg_cnt = 0, fails = 0, checked = 0, writes = 0, settings = 0;
  bit          mask_done [wtrs_pkg::NumVnets][wtrs_pkg::NumLinks];
  logic [7:0]  gen_id = 8'd0;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    return {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
  endfunction

  function automatic wtrs_pkg::out_item_t table_route(input logic [1:0] vn,
                                                      input logic [63:0] want);
    wtrs_pkg::out_item_t r;
    logic [16:0] best;
    int cnt, pick, seen;
    r = '{out_port: 4'd0, no_route: 1'b1};
    best = 17'h10000;
    cnt = 0;
    seen = 0;
    for (int k = 0; k < wtrs_pkg::NumLinks; k++) begin
      if (mdl_valid[k] && (mdl_masks[vn][k] & want) != 0) begin
        if ({1'b0, mdl_weights[k]} < best) begin
          best = {1'b0, mdl_weights[k]};
          cnt = 0;
        end
        if ({1'b0, mdl_weights[k]} == best) cnt++;
      end
    end
    if (cnt == 0) return r;
    pick = 0;
    if (!mdl_ordered[vn]) begin
      mdl_lfsr = lfsr_next(mdl_lfsr);
      pick = int'(mdl_lfsr) % cnt;
    end
    for (int k = 0; k < wtrs_pkg::NumLinks; k++) begin
      if (mdl_valid[k] && (mdl_masks[vn][k] & want) != 0
          && {1'b0, mdl_weights[k]} == best) begin
        if (seen == pick) begin
          r.out_port = k[3:0];
          r.no_route = 1'b0;
          return r;
        end
        seen++;
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] xy_route(input logic [7:0] dst);
    int cols, mx, my, dx, dy;
    cols = (mdl_cols == 0) ? 1 : int'(mdl_cols);
    mx = int'(mdl_id) % cols;
    my = int'(mdl_id) / cols;
    dx = int'(dst) % cols;
    dy = int'(dst) / cols;
    if (dx != mx) return (dx > mx) ? mdl_east : mdl_west;
    return (dy >= my) ? mdl_north : mdl_south;
  endfunction

  // Update tables for an accepted item; queue the route it calls for.
  task automatic apply_item(input wtrs_pkg::in_item_t it);
    wtrs_pkg::out_item_t r;
    case (it.kind)
      wtrs_pkg::KindMask: mdl_masks[it.vnet][it.link] = it.dest_mask;
      wtrs_pkg::KindWeight: begin
        mdl_weights[it.link] = it.weight;
        mdl_valid[it.link] = 1'b1;
      end
      wtrs_pkg::KindRoute: begin
        if (!mdl_mode || it.dst_id == mdl_id)
          r = table_route(it.vnet, it.dest_mask);
        else
          r = '{out_port: xy_route(it.dst_id), no_route: 1'b0};
        route_q = {route_q, r};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wtrs_pkg::CfgRoutingMode: mdl_mode = cfg_data_i[0];
          wtrs_pkg::CfgMeshCols:    mdl_cols = cfg_data_i;
          wtrs_pkg::CfgRouterId:    mdl_id = cfg_data_i;
          wtrs_pkg::CfgOrdered:     mdl_ordered = cfg_data_i[3:0];
          wtrs_pkg::CfgPortEast:    mdl_east = cfg_data_i[3:0];
          wtrs_pkg::CfgPortWest:    mdl_west = cfg_data_i[3:0];
          wtrs_pkg::CfgPortNorth:   mdl_north = cfg_data_i[3:0];
          wtrs_pkg::CfgPortSouth:   mdl_south = cfg_data_i[3:0];
          default: ;
        endcase
        cfg_cnt++;
      end
      if (in_valid_i && in_ready_o) apply_item(in_item_i);
      if (out_valid_o && out_ready_i) begin
        if (route_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result port=%0d none=%0b",
                                    out_item_o.out_port, out_item_o.no_route);
        end else begin
          wtrs_pkg::out_item_t want;
          want = route_q.pop_front();
          checked++;
          if (out_item_o.out_port !== want.out_port || out_item_o.no_route !== want.no_route)
          begin
            fails++;
            if (fails <= 10)
              $display("route mismatch: expected port=%0d none=%0b, got port=%0d none=%0b",
                       want.out_port, want.no_route, out_item_o.out_port,
                       out_item_o.no_route);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (item_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_item_i <= item_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [wtrs_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    int seen;
    seen = cfg_cnt;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    wait (cfg_cnt != seen);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic mode, input logic [7:0] cols, input logic [7:0] id,
                          input logic [3:0] ord, input logic [3:0] e, input logic [3:0] w,
                          input logic [3:0] n, input logic [3:0] s);
    write_reg(wtrs_pkg::CfgRoutingMode, {7'd0, mode});
    write_reg(wtrs_pkg::CfgMeshCols, cols);
    write_reg(wtrs_pkg::CfgRouterId, id);
    write_reg(wtrs_pkg::CfgOrdered, {4'd0, ord});
    write_reg(wtrs_pkg::CfgPortEast, {4'd0, e});
    write_reg(wtrs_pkg::CfgPortWest, {4'd0, w});
    write_reg(wtrs_pkg::CfgPortNorth, {4'd0, n});
    write_reg(wtrs_pkg::CfgPortSouth, {4'd0, s});
    gen_id = id;
    settings++;
  endtask

  task automatic push(input logic [1:0] kind, input logic [1:0] vn, input logic [3:0] lk,
                      input logic [63:0] m, input logic [15:0] w, input logic [7:0] dst);
    wtrs_pkg::in_item_t it;
    it = '{kind: kind, vnet: vn, link: lk, dest_mask: m, weight: w, dst_id: dst};
    if (kind == wtrs_pkg::KindMask) mask_done[vn][lk] = 1'b1;
    if (kind == wtrs_pkg::KindMask || kind == wtrs_pkg::KindWeight) writes++;
    item_q = {item_q, it};
  endtask

  function automatic logic [63:0] any_mask();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return 64'd1 << $urandom_range(0, 63);
      2: return '1;
      3: return '0;
      default: return {56'd0, 8'($urandom)};
    endcase
  endfunction

  // Weight writes only go to links whose masks are all set, so no lookup
  // ever meets an unwritten mask.
  task automatic gen_items(input int n);
    int r;
    logic [3:0] lk;
    logic [15:0] w;
    logic [7:0] dst;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      lk = 4'($urandom);
      if (r < 4) begin
        push(wtrs_pkg::KindSpare, 2'($urandom), lk, {$urandom, $urandom}, 16'($urandom),
             8'($urandom));
        i--;
      end else if (r < 22) begin
        push(wtrs_pkg::KindMask, 2'($urandom), lk, any_mask(), 16'($urandom), 8'($urandom));
      end else if (r < 34) begin
        for (int v = 0; v < wtrs_pkg::NumVnets; v++)
          if (!mask_done[v][lk])
            push(wtrs_pkg::KindMask, 2'(v), lk, any_mask(), 16'($urandom), 8'($urandom));
        case ($urandom_range(0, 7))
          0: w = 16'hFFFF;
          1: w = 16'($urandom);
          default: w = 16'($urandom_range(0, 3));
        endcase
        push(wtrs_pkg::KindWeight, 2'($urandom), lk, {$urandom, $urandom}, w, 8'($urandom));
      end else begin
        dst = ($urandom_range(0, 9) == 0) ? gen_id : 8'($urandom);
        push(wtrs_pkg::KindRoute, 2'($urandom), lk, any_mask(), 16'($urandom), dst);
      end
    end
  endtask

  task automatic drain();
    wait (item_q.size() == 0 && !in_valid_i && route_q.size() == 0);
    repeat (60) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, ignored kind, extreme masks and weights, ties.
    push(wtrs_pkg::KindRoute, 2'd0, 4'd0, '1, 16'd0, 8'd0);
    push(wtrs_pkg::KindSpare, 2'd3, 4'd15, '1, 16'hFFFF, 8'hFF);
    for (int v = 0; v < wtrs_pkg::NumVnets; v++) begin
      push(wtrs_pkg::KindMask, 2'(v), 4'd0, '1, 16'd0, 8'd0);
      push(wtrs_pkg::KindMask, 2'(v), 4'd1, 64'd1, 16'd0, 8'd0);
      push(wtrs_pkg::KindMask, 2'(v), 4'd15, 64'h8000_0000_0000_0000, 16'd0, 8'd0);
    end
    push(wtrs_pkg::KindWeight, 2'd0, 4'd0, '0, 16'hFFFF, 8'd0);
    push(wtrs_pkg::KindWeight, 2'd3, 4'd1, '0, 16'd0, 8'd0);
    push(wtrs_pkg::KindWeight, 2'd1, 4'd15, '0, 16'd0, 8'd0);
    push(wtrs_pkg::KindRoute, 2'd0, 4'd0, 64'd1, 16'd0, 8'd0);
    push(wtrs_pkg::KindRoute, 2'd3, 4'd0, 64'h8000_0000_0000_0000, 16'd0, 8'hFF);
    push(wtrs_pkg::KindRoute, 2'd1, 4'd0, '0, 16'd0, 8'd0);
    push(wtrs_pkg::KindRoute, 2'd2, 4'd0, '1, 16'd0, 8'd0);
    drain();

    set_regs(1'b0, 8'd4, 8'd0, 4'h0, 4'd0, 4'd1, 4'd2, 4'd3);
    gen_items(200);
    drain();
    idle_ok = 1'b0;
    set_regs(1'b0, 8'd4, 8'd3, 4'hF, 4'd0, 4'd1, 4'd2, 4'd3);
    gen_items(180);
    drain();
    idle_ok = 1'b1;
    set_regs(1'b1, 8'd1, 8'd0, 4'h5, 4'd4, 4'd5, 4'd6, 4'd7);
    gen_items(180);
    drain();
    set_regs(1'b1, 8'd255, 8'd255, 4'hA, 4'd15, 4'd14, 4'd13, 4'd12);
    gen_items(180);
    drain();
    set_regs(1'b1, 8'd0, 8'd200, 4'h3, 4'd8, 4'd9, 4'd10, 4'd11);
    gen_items(180);
    drain();
    set_regs(1'b1, 8'd7, 8'd23, 4'h0, 4'd0, 4'd15, 4'd0, 4'd15);
    gen_items(180);
    drain();
    idle_ok = 1'b0;
    set_regs(1'b0, 8'd3, 8'd9, 4'h5, 4'd1, 4'd2, 4'd4, 4'd8);
    gen_items(180);
    drain();

    if (route_q.size() != 0) fails++;
    $display("covered %0d checked routes and %0d table writes over %0d register settings",
             checked, writes, settings);
    $display("table and XY modes, ordered and random picks, %0d failures", fails);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
